>>> hw/rtl/psdh_pkg.sv
// Shared types, widths and helpers for the point to segment distance block.
package psdh_pkg;

  localparam int unsigned CoordWidth = 24;
  localparam int unsigned CfgWidth = 8;
  localparam logic [CfgWidth-1:0] NearZeroReset = 8'd1;

  typedef struct packed {
    logic signed [CoordWidth-1:0] seg_ax;
    logic signed [CoordWidth-1:0] seg_ay;
    logic signed [CoordWidth-1:0] seg_bx;
    logic signed [CoordWidth-1:0] seg_by;
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic [CoordWidth-2:0]        radius;
  } in_t;

  typedef struct packed {
    logic [CoordWidth-1:0] distance;
    logic                  hit;
  } out_t;

  typedef struct packed {
    logic                  vert;
    logic                  horiz;
    logic                  out_v;
    logic                  out_h;
    logic                  end_sel;
    logic [CoordWidth-1:0] ra;
    logic [CoordWidth-1:0] rb;
    logic [CoordWidth-2:0] radius;
  } side_t;

  function automatic logic [CoordWidth-1:0] diff_mag(input logic signed [CoordWidth:0] v);
    logic [CoordWidth:0] n;
    n = v[CoordWidth] ? (CoordWidth+1)'(-v) : (CoordWidth+1)'(v);
    return n[CoordWidth-1:0];
  endfunction

endpackage

>>> hw/rtl/psdh_root.sv
// Bit-per-stage root pipeline: two endpoint square roots and the perpendicular search.
module psdh_root (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [2*psdh_pkg::CoordWidth:0]        sum_a_i,
  input  logic [2*psdh_pkg::CoordWidth:0]        sum_b_i,
  input  logic [2*psdh_pkg::CoordWidth:0]        len2_i,
  input  logic [4*psdh_pkg::CoordWidth+1:0]      q2_i,
  input  psdh_pkg::side_t                        side_i,
  output logic                                   valid_o,
  output logic [psdh_pkg::CoordWidth-1:0]        dist_a_o,
  output logic [psdh_pkg::CoordWidth-1:0]        dist_b_o,
  output logic [psdh_pkg::CoordWidth-1:0]        dist_p_o,
  output psdh_pkg::side_t                        side_o
);

  localparam int unsigned W  = psdh_pkg::CoordWidth;
  localparam int unsigned NS = W + 1;
  localparam int unsigned SW = 2*W + 1;
  localparam int unsigned RW = 2*W + 3;
  localparam int unsigned QW = 4*W + 2;
  localparam int unsigned TW = 4*W + 3;
  localparam int unsigned DW = 3*W + 1;

  logic            v_q    [NS+1];
  logic [RW-1:0]   rem_a_q[NS+1];
  logic [RW-1:0]   rem_b_q[NS+1];
  logic [W:0]      rt_a_q [NS+1];
  logic [W:0]      rt_b_q [NS+1];
  logic [QW-1:0]   rp_q   [NS+1];
  logic [DW-1:0]   dacc_q [NS+1];
  logic [W-1:0]    dq_q   [NS+1];
  logic [SW-1:0]   ln_q   [NS+1];
  psdh_pkg::side_t sd_q   [NS+1];

  assign v_q[0]     = valid_i;
  assign rem_a_q[0] = RW'(sum_a_i);
  assign rem_b_q[0] = RW'(sum_b_i);
  assign rt_a_q[0]  = '0;
  assign rt_b_q[0]  = '0;
  assign rp_q[0]    = q2_i;
  assign dacc_q[0]  = '0;
  assign dq_q[0]    = '0;
  assign ln_q[0]    = len2_i;
  assign sd_q[0]    = side_i;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int unsigned J = W - i;
    logic [RW-1:0] ta, tb;

    assign ta = (RW'(rt_a_q[i]) << (J+1)) + (RW'(1) << (2*J));
    assign tb = (RW'(rt_b_q[i]) << (J+1)) + (RW'(1) << (2*J));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[i+1] <= sd_q[i];
        ln_q[i+1] <= ln_q[i];
        if (ta <= rem_a_q[i]) begin
          rem_a_q[i+1] <= rem_a_q[i] - ta;
          rt_a_q[i+1]  <= rt_a_q[i] | ((W+1)'(1) << J);
        end else begin
          rem_a_q[i+1] <= rem_a_q[i];
          rt_a_q[i+1]  <= rt_a_q[i];
        end
        if (tb <= rem_b_q[i]) begin
          rem_b_q[i+1] <= rem_b_q[i] - tb;
          rt_b_q[i+1]  <= rt_b_q[i] | ((W+1)'(1) << J);
        end else begin
          rem_b_q[i+1] <= rem_b_q[i];
          rt_b_q[i+1]  <= rt_b_q[i];
        end
      end
    end

    if (J == W) begin : g_skip
      // a set top bit would exceed the saturated maximum
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rp_q[i+1]   <= rp_q[i];
          dacc_q[i+1] <= dacc_q[i];
          dq_q[i+1]   <= dq_q[i];
        end
      end
    end else begin : g_perp
      logic [TW-1:0] tp;
      assign tp = (TW'(dacc_q[i]) << (J+1)) + (TW'(ln_q[i]) << (2*J));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (tp <= TW'(rp_q[i])) begin
            rp_q[i+1]   <= rp_q[i] - QW'(tp);
            dacc_q[i+1] <= dacc_q[i] + (DW'(ln_q[i]) << J);
            dq_q[i+1]   <= dq_q[i] | (W'(1) << J);
          end else begin
            rp_q[i+1]   <= rp_q[i];
            dacc_q[i+1] <= dacc_q[i];
            dq_q[i+1]   <= dq_q[i];
          end
        end
      end
    end
  end

  assign valid_o  = v_q[NS];
  assign dist_a_o = rt_a_q[NS][W] ? '1 : rt_a_q[NS][W-1:0];
  assign dist_b_o = rt_b_q[NS][W] ? '1 : rt_b_q[NS][W-1:0];
  assign dist_p_o = dq_q[NS];
  assign side_o   = sd_q[NS];

endmodule

>>> hw/rtl/point_segment_distance_hit.sv
// Top level: point to segment distance with circle hit test.
// Takes one query per clock while the output is not stalled and returns
// results in order through five arithmetic stages, one root stage per
// result bit over 25 stages and one output register. A stalled output
// holds the whole pipeline. near_zero (reset to 1) is written through
// cfg_we_i/cfg_data_i, by the user only while idle; not enforced here.
module point_segment_distance_hit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  psdh_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psdh_pkg::out_t                out_o,
  input  logic                          cfg_we_i,
  input  logic [psdh_pkg::CfgWidth-1:0] cfg_data_i
);

  localparam int unsigned W  = psdh_pkg::CoordWidth;
  localparam int unsigned PW = 2*W + 2;
  localparam int unsigned SW = 2*W + 1;
  localparam int unsigned QW = 4*W + 2;

  logic [psdh_pkg::CfgWidth-1:0] near_zero_q;
  logic en;
  logic out_valid_q;
  psdh_pkg::out_t out_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_zero_q <= psdh_pkg::NearZeroReset;
    end else if (cfg_we_i) begin
      near_zero_q <= cfg_data_i;
    end
  end

  // stage 1: differences and axis tests
  logic signed [W:0] ax, ay, bx, by, px, py;
  logic signed [W:0] ex_d, ey_d, rx_d, ry_d, sx_d, sy_d;
  psdh_pkg::side_t side1_d;

  assign ax = (W+1)'(in_i.seg_ax);
  assign ay = (W+1)'(in_i.seg_ay);
  assign bx = (W+1)'(in_i.seg_bx);
  assign by = (W+1)'(in_i.seg_by);
  assign px = (W+1)'(in_i.point_x);
  assign py = (W+1)'(in_i.point_y);
  assign ex_d = bx - ax;
  assign ey_d = by - ay;
  assign rx_d = px - ax;
  assign ry_d = py - ay;
  assign sx_d = px - bx;
  assign sy_d = py - by;

  always_comb begin
    side1_d.vert    = psdh_pkg::diff_mag(ex_d) <= W'(near_zero_q);
    side1_d.horiz   = psdh_pkg::diff_mag(ey_d) <= W'(near_zero_q);
    side1_d.out_v   = (py <= ay && py <= by) || (py >= ay && py >= by);
    side1_d.out_h   = (px <= ax && px <= bx) || (px >= ax && px >= bx);
    side1_d.end_sel = 1'b0;
    side1_d.ra      = psdh_pkg::diff_mag(rx_d);
    side1_d.rb      = psdh_pkg::diff_mag(ry_d);
    side1_d.radius  = in_i.radius;
  end

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [W:0] ex1_q, ey1_q, rx1_q, ry1_q, sx1_q, sy1_q;
  psdh_pkg::side_t side1_q, side2_q, side3_q, side4_q, side5_q;

  // stage 2: products
  logic signed [PW-1:0] rxx_q, ryy_q, sxx_q, syy_q, exx_q, eyy_q;
  logic signed [PW-1:0] exrx_q, eyry_q, exry_q, eyrx_q;

  // stage 3: sums
  logic [SW-1:0]          sa3_q, sb3_q, len3_q, crm3_q;
  logic signed [PW:0]     dot3_q;
  logic signed [PW:0]     cr_s;
  logic [PW:0]            cr_m;

  assign cr_s  = (PW+1)'(exry_q) - (PW+1)'(eyrx_q);
  assign cr_m  = cr_s[PW] ? (PW+1)'(-cr_s) : (PW+1)'(cr_s);

  // stage 4: range test and square of the cross product in parts
  logic [SW-1:0]    sa4_q, sb4_q, len4_q;
  logic [2*W-1:0]   hh4_q;
  logic [2*W:0]     hl4_q;
  logic [2*W+1:0]   ll4_q;
  logic [W-1:0]     cr_hi;
  logic [W:0]       cr_lo;
  logic             end_sel;
  psdh_pkg::side_t  side4_d;

  assign cr_hi   = crm3_q[2*W:W+1];
  assign cr_lo   = crm3_q[W:0];
  assign end_sel = (dot3_q <= 0) || (dot3_q >= $signed({2'b00, len3_q}));

  always_comb begin
    side4_d         = side3_q;
    side4_d.end_sel = end_sel;
  end

  // stage 5: reassembled square
  logic [SW-1:0] sa5_q, sb5_q, len5_q;
  logic [QW-1:0] q2_5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex1_q   <= ex_d;
      ey1_q   <= ey_d;
      rx1_q   <= rx_d;
      ry1_q   <= ry_d;
      sx1_q   <= sx_d;
      sy1_q   <= sy_d;
      side1_q <= side1_d;

      rxx_q   <= PW'(rx1_q) * PW'(rx1_q);
      ryy_q   <= PW'(ry1_q) * PW'(ry1_q);
      sxx_q   <= PW'(sx1_q) * PW'(sx1_q);
      syy_q   <= PW'(sy1_q) * PW'(sy1_q);
      exx_q   <= PW'(ex1_q) * PW'(ex1_q);
      eyy_q   <= PW'(ey1_q) * PW'(ey1_q);
      exrx_q  <= PW'(ex1_q) * PW'(rx1_q);
      eyry_q  <= PW'(ey1_q) * PW'(ry1_q);
      exry_q  <= PW'(ex1_q) * PW'(ry1_q);
      eyrx_q  <= PW'(ey1_q) * PW'(rx1_q);
      side2_q <= side1_q;

      sa3_q   <= SW'(rxx_q[2*W-1:0]) + SW'(ryy_q[2*W-1:0]);
      sb3_q   <= SW'(sxx_q[2*W-1:0]) + SW'(syy_q[2*W-1:0]);
      len3_q  <= SW'(exx_q[2*W-1:0]) + SW'(eyy_q[2*W-1:0]);
      dot3_q  <= $signed({exrx_q[PW-1], exrx_q}) + $signed({eyry_q[PW-1], eyry_q});
      crm3_q  <= cr_m[SW-1:0];
      side3_q <= side2_q;

      sa4_q   <= sa3_q;
      sb4_q   <= sb3_q;
      len4_q  <= len3_q;
      hh4_q   <= (2*W)'(cr_hi) * (2*W)'(cr_hi);
      hl4_q   <= (2*W+1)'(cr_hi) * (2*W+1)'(cr_lo);
      ll4_q   <= (2*W+2)'(cr_lo) * (2*W+2)'(cr_lo);
      side4_q <= side4_d;

      sa5_q   <= sa4_q;
      sb5_q   <= sb4_q;
      len5_q  <= len4_q;
      q2_5_q  <= (QW'(hh4_q) << (2*W+2)) + (QW'(hl4_q) << (W+2)) + QW'(ll4_q);
      side5_q <= side4_q;
    end
  end

  logic            vr;
  logic [W-1:0]    dist_a, dist_b, dist_p, dmin;
  psdh_pkg::side_t sider;
  psdh_pkg::out_t  out_d;

  psdh_root u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v5_q),
    .sum_a_i  (sa5_q),
    .sum_b_i  (sb5_q),
    .len2_i   (len5_q),
    .q2_i     (q2_5_q),
    .side_i   (side5_q),
    .valid_o  (vr),
    .dist_a_o (dist_a),
    .dist_b_o (dist_b),
    .dist_p_o (dist_p),
    .side_o   (sider)
  );

  always_comb begin
    dmin = (dist_a < dist_b) ? dist_a : dist_b;
    if (sider.vert) begin
      out_d.distance = sider.out_v ? dmin : sider.ra;
    end else if (sider.horiz) begin
      out_d.distance = sider.out_h ? dmin : sider.rb;
    end else begin
      out_d.distance = sider.end_sel ? dmin : dist_p;
    end
    out_d.hit = out_d.distance <= W'(sider.radius);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule
